// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i once reset is released.
`define ASSERT_ON_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every rising edge of clk_i once reset is released.
`define ASSERT_IMPLY(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ----- rtl/cpd_pkg.sv -----
// Shared constants, types and sequencer states of the closest pair block.
`default_nettype none

package cpd_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_POINTS_DEF  = 1024;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed port widths
  localparam int IN_W            = 16;
  localparam int SQ_W            = 33;
  localparam logic [SQ_W-1:0] SQ_CAP = {SQ_W{1'b1}};

  // Square root: one result bit per step, radicand is the squared value times 2^32
  localparam int SQRT_STEPS      = 33;
  localparam int SQRT_CNT_W      = 6;
  localparam int RAD_W           = 2 * SQRT_STEPS;
  localparam int REM_W           = 36;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_RD,
    S_ROW_LATCH,
    S_ISSUE,
    S_GAP,
    S_DRAIN,
    S_SQRT,
    S_WRES
  } state_e;

  // Sequencer commands to the pair datapath
  typedef struct packed {
    logic clear;     // reset running minimum
    logic row_load;  // latch the row point from the read word
    logic issue;     // a column point read was issued this cycle
  } pair_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/cpd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/cpd_pair.sv -----
// Pair distance datapath: difference stage, shared squarer and running minimum.
`default_nettype none

module cpd_pair #(
  parameter int COORD_BITS = cpd_pkg::COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cpd_pkg::pair_ctrl_t      ctrl_i,
  input  logic [COORD_BITS-1:0]    rd_x_i,
  input  logic [COORD_BITS-1:0]    rd_y_i,
  output logic [cpd_pkg::SQ_W-1:0] best_o,
  output logic                     busy_o
);

  localparam int CW = COORD_BITS;
  localparam int PW = 2 * COORD_BITS;
  localparam int SW = cpd_pkg::SQ_W;

  logic [CW-1:0] px_q, py_q;
  logic [CW-1:0] dx_q, dy_q;
  logic [PW-1:0] sq_x_q, sq_y_q;
  logic          rd_v_q, diff_v_q, sqx_v_q, sqy_v_q;
  logic [SW-1:0] best_q;

  logic signed [CW:0] diff_x, diff_y;
  logic [CW:0]        neg_x, neg_y;
  logic [CW-1:0]      dx_abs, dy_abs;
  logic [CW-1:0]      mul_op;
  logic [PW-1:0]      mul_res;
  logic [63:0]        sx_wide, sy_wide;
  logic [SW-1:0]      sx_sat, sy_sat;
  logic [SW:0]        dist_sum;
  logic [SW-1:0]      pair_dist;

  // Absolute coordinate differences against the row point
  assign diff_x = $signed({rd_x_i[CW-1], rd_x_i}) - $signed({px_q[CW-1], px_q});
  assign diff_y = $signed({rd_y_i[CW-1], rd_y_i}) - $signed({py_q[CW-1], py_q});
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;
  assign dx_abs = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
  assign dy_abs = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];

  // Shared squarer: dx while the difference stage is valid, then dy while the dx square is valid
  assign mul_op  = sqx_v_q ? dy_q : dx_q;
  assign mul_res = PW'(mul_op) * PW'(mul_op);

  // Saturate each square and the sum to the result width
  assign sx_wide   = 64'(sq_x_q);
  assign sy_wide   = 64'(sq_y_q);
  assign sx_sat    = (sx_wide > 64'(cpd_pkg::SQ_CAP)) ? cpd_pkg::SQ_CAP : sx_wide[SW-1:0];
  assign sy_sat    = (sy_wide > 64'(cpd_pkg::SQ_CAP)) ? cpd_pkg::SQ_CAP : sy_wide[SW-1:0];
  assign dist_sum  = {1'b0, sx_sat} + {1'b0, sy_sat};
  assign pair_dist = (dist_sum > {1'b0, cpd_pkg::SQ_CAP}) ? cpd_pkg::SQ_CAP : dist_sum[SW-1:0];

  // Advance stage valids and track the minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      diff_v_q <= 1'b0;
      sqx_v_q  <= 1'b0;
      sqy_v_q  <= 1'b0;
      best_q   <= '1;
    end else begin
      rd_v_q   <= ctrl_i.issue;
      diff_v_q <= rd_v_q;
      sqx_v_q  <= diff_v_q;
      sqy_v_q  <= sqx_v_q;
      if (ctrl_i.clear) begin
        best_q <= '1;
      end else if (sqy_v_q && (pair_dist < best_q)) begin
        best_q <= pair_dist;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.row_load) begin
      px_q <= rd_x_i;
      py_q <= rd_y_i;
    end
    if (rd_v_q) begin
      dx_q <= dx_abs;
      dy_q <= dy_abs;
    end
    if (diff_v_q) begin
      sq_x_q <= mul_res;
    end
    if (sqx_v_q) begin
      sq_y_q <= mul_res;
    end
  end

  assign best_o = best_q;
  assign busy_o = rd_v_q | diff_v_q | sqx_v_q | sqy_v_q;

endmodule

`default_nettype wire

// ----- rtl/cpd_sqrt.sv -----
// Bit-serial square root giving floor(sqrt(value * 2^32)), one root bit per cycle.
`default_nettype none

module cpd_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [cpd_pkg::SQ_W-1:0] value_i,
  output logic                     busy_o,
  output logic [cpd_pkg::SQ_W-1:0] root_o
);

  localparam int RW = cpd_pkg::RAD_W;
  localparam int MW = cpd_pkg::REM_W;
  localparam int SW = cpd_pkg::SQ_W;

  logic                           busy_q;
  logic [cpd_pkg::SQRT_CNT_W-1:0] cnt_q;
  logic [RW-1:0]                  rad_q;
  logic [MW-1:0]                  rem_q;
  logic [SW-1:0]                  root_q;

  logic [MW-1:0] rem_sh;
  logic [MW-1:0] trial;
  logic          fits;

  // Bring down two radicand bits and try a one in the next root bit
  assign rem_sh = {rem_q[MW-3:0], rad_q[RW-1 -: 2]};
  assign trial  = MW'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cpd_pkg::SQRT_CNT_W'(cpd_pkg::SQRT_STEPS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RW'({1'b0, value_i, 32'h0});
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RW-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[SW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ----- rtl/closest_pair_distance.sv -----
// Top level: point loading, pair scan sequencer and result register.
//
//   channel   direction  words                                         handshake
//   in        input      point_x_i, point_y_i, last_point_i            in_valid_i / in_ready_o
//   out       output     min_dist_squared_o, min_distance_o, no_pair_o, out_valid_o / out_ready_i
//                        overflow_o
//
// A point word without last_point_i is stored, or dropped when the RAM is full, and the block
// stays ready for the next word. The closing word of a set of two or more points starts a
// scan: the shared squarer takes dx then dy of each pair, each row reloads its point through the
// single RAM read port, and the square root then yields its result one bit at a time.
// Reset clears the sequencer, the point count and the output valid; the point RAM
// is not cleared, the scan reads only entries written in the current set.
// in_ready_o is low during a scan; a held result does not stall loading, only the delivery of the next result.
`default_nettype none

`include "assert_macros.svh"

module closest_pair_distance #(
  parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cpd_pkg::COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [cpd_pkg::IN_W-1:0] point_x_i,
  input  logic [cpd_pkg::IN_W-1:0] point_y_i,
  input  logic                     last_point_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [cpd_pkg::SQ_W-1:0] min_dist_squared_o,
  output logic [cpd_pkg::SQ_W-1:0] min_distance_o,
  output logic                     no_pair_o,
  output logic                     overflow_o
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int SW   = cpd_pkg::SQ_W;

  cpd_pkg::state_e state_q, state_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] i_q, i_d;
  logic [CNTW-1:0] j_q, j_d;
  logic            dropped_q, dropped_d;
  logic            out_valid_q;

  logic [SW-1:0]   min_dist_squared_q;
  logic [SW-1:0]   min_distance_q;
  logic            no_pair_q;
  logic            overflow_q;

  cpd_pkg::pair_ctrl_t pair_ctrl;
  logic            pair_busy;
  logic [SW-1:0]   best;
  logic            sq_start;
  logic            sq_busy;
  logic [SW-1:0]   root;
  logic            res_load;
  logic            ram_we;

  logic [31:0]     x_ext, y_ext;
  logic [2*CW-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]   ram_raddr;
  logic            has_room;
  logic            last_j, last_row, none;

  // Take the low coordinate bits of each word
  assign x_ext     = {16'h0, point_x_i};
  assign y_ext     = {16'h0, point_y_i};
  assign ram_wdata = {x_ext[CW-1:0], y_ext[CW-1:0]};
  assign ram_raddr = (state_q == cpd_pkg::S_ROW_RD) ? i_q[AW-1:0] : j_q[AW-1:0];

  assign has_room = count_q < CNTW'(MAX_POINTS);
  assign last_j   = j_q == (count_q - CNTW'(1));
  assign last_row = (i_q + CNTW'(2)) == count_q;
  assign none     = count_q < CNTW'(2);

  cpd_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cpd_pair #(
    .COORD_BITS(COORD_BITS)
  ) u_pair (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(pair_ctrl),
    .rd_x_i(ram_rdata[2*CW-1:CW]),
    .rd_y_i(ram_rdata[CW-1:0]),
    .best_o(best),
    .busy_o(pair_busy)
  );

  cpd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .value_i(best),
    .busy_o (sq_busy),
    .root_o (root)
  );

  // Sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpd_pkg::S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      dropped_q   <= dropped_d;
      out_valid_q <= res_load | (out_valid_q & ~out_ready_i);
    end
  end

  // Next state: load words, walk rows and columns, drain, root, deliver
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    i_d       = i_q;
    j_d       = j_q;
    dropped_d = dropped_q;
    pair_ctrl = '0;
    sq_start  = 1'b0;
    res_load  = 1'b0;
    ram_we    = 1'b0;
    case (state_q)
      cpd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (has_room) begin
            ram_we  = 1'b1;
            count_d = count_q + CNTW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_point_i) begin
            if (count_d < CNTW'(2)) begin
              state_d = cpd_pkg::S_WRES;
            end else begin
              i_d             = '0;
              j_d             = CNTW'(1);
              pair_ctrl.clear = 1'b1;
              state_d         = cpd_pkg::S_ROW_RD;
            end
          end
        end
      end
      cpd_pkg::S_ROW_RD: begin
        state_d = cpd_pkg::S_ROW_LATCH;
      end
      cpd_pkg::S_ROW_LATCH: begin
        pair_ctrl.row_load = 1'b1;
        state_d            = cpd_pkg::S_ISSUE;
      end
      cpd_pkg::S_ISSUE: begin
        pair_ctrl.issue = 1'b1;
        if (!last_j) begin
          j_d     = j_q + CNTW'(1);
          state_d = cpd_pkg::S_GAP;
        end else if (last_row) begin
          state_d = cpd_pkg::S_DRAIN;
        end else begin
          i_d     = i_q + CNTW'(1);
          j_d     = i_q + CNTW'(2);
          state_d = cpd_pkg::S_ROW_RD;
        end
      end
      cpd_pkg::S_GAP: begin
        state_d = cpd_pkg::S_ISSUE;
      end
      cpd_pkg::S_DRAIN: begin
        if (!pair_busy) begin
          sq_start = 1'b1;
          state_d  = cpd_pkg::S_SQRT;
        end
      end
      cpd_pkg::S_SQRT: begin
        if (!sq_busy) begin
          state_d = cpd_pkg::S_WRES;
        end
      end
      cpd_pkg::S_WRES: begin
        if (!out_valid_q || out_ready_i) begin
          res_load  = 1'b1;
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = cpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cpd_pkg::S_IDLE;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      min_dist_squared_q <= none ? '0 : best;
      min_distance_q     <= none ? '0 : root;
      no_pair_q          <= none;
      overflow_q         <= dropped_q;
    end
  end

  assign in_ready_o         = state_q == cpd_pkg::S_IDLE;
  assign out_valid_o        = out_valid_q;
  assign min_dist_squared_o = min_dist_squared_q;
  assign min_distance_o     = min_distance_q;
  assign no_pair_o          = no_pair_q;
  assign overflow_o         = overflow_q;

  `ASSERT_IMPLY(a_idle_pipe_empty, in_ready_o, !pair_busy && !sq_busy, "scan active while loading")
  `ASSERT_IMPLY(a_sqrt_after_scan, sq_busy, !pair_busy, "root started before scan drained")
  `ASSERT_IMPLY(a_issue_spacing, $past(pair_ctrl.issue), !pair_ctrl.issue, "squarer overbooked")
  `ASSERT_ON_CLK(a_count_bound, count_q <= CNTW'(MAX_POINTS), "point count above capacity")

endmodule

`default_nettype wire
